// ===== design/aks_pkg.sv =====
// shared constants for the anomaly kill switch
`default_nettype none
package aks_pkg;

    localparam int LAT_DEPTH   = 64;
    localparam int LAT_AW      = $clog2(LAT_DEPTH);
    localparam int LAT_CW      = $clog2(LAT_DEPTH + 1);
    localparam int RATE_DEPTH  = 100;
    localparam int RATE_AW     = $clog2(RATE_DEPTH);
    localparam int RATE_CW     = $clog2(RATE_DEPTH + 1);
    localparam int RATE_MEM_AW = $clog2(2 * RATE_DEPTH);

    localparam int TIME_W  = 32;
    localparam int VAL_W   = 24;
    localparam int RATE_W  = 16;
    localparam int LSUM_W  = 30;
    localparam int LSQ_W   = 54;
    localparam int RSUM_W  = 23;
    localparam int SCORE_W = 24;
    localparam int LENT_W  = TIME_W + VAL_W;

    localparam int NQ_W   = LAT_CW + LSQ_W;
    localparam int SS_W   = 2 * LSUM_W;
    localparam int D_W    = 62;
    localparam int ROOT_W = D_W / 2;
    localparam int DIV_W  = 48;
    localparam int DVS_W  = 31;

    localparam logic [2:0] CMD_LATENCY = 3'd0;
    localparam logic [2:0] CMD_ERROR   = 3'd1;
    localparam logic [2:0] CMD_REJECT  = 3'd2;
    localparam logic [2:0] CMD_TICK    = 3'd3;
    localparam logic [2:0] CMD_RESET   = 3'd4;

    localparam logic [1:0] MODE_CLOSED = 2'd0;
    localparam logic [1:0] MODE_OPEN   = 2'd1;
    localparam logic [1:0] MODE_HALF   = 2'd2;

    localparam logic [1:0] REG_WINDOW    = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_AUTORESET = 2'd2;

    localparam logic [14:0] ERR_CAP = 15'd19660;
    localparam logic [13:0] REJ_CAP = 14'd13107;

endpackage
`default_nettype wire

// ===== design/aks_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module aks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/anomaly_kill_switch_top.sv =====
// circuit breaker top level: sample rings, score engine and switch state
// flow: tick, reset and unused requests go straight to the result; a latency sample
//   retires the oldest entry when the ring is full, is written, prunes expired samples,
//   then the score takes a square root and a divide, plus one divide per nonempty rate ring
// throughput: one request at a time, next taken while a result waits; a rate request
//   updates its ring and then rescores only while latency samples are held
// reset: rst_n asynchronous, clears counters, sums, score and mode; config to defaults
`default_nettype none
module anomaly_kill_switch_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // now_ms[31:0], sample_value[55:32]
    input  wire logic [2:0]  s_axis_tuser,   // command[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // switch_state[1:0], block_orders[2],
                                             // anomaly_score[26:3], tripped[27]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    import aks_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_LRD_FULL, S_LSQ_FULL, S_LSUB_FULL, S_LWR, S_LADD,
        S_PRD, S_PCHK, S_PSUB, S_RRD, S_RSUB, S_RWR,
        S_EVAL, S_EMUL, S_ESUB, S_SQRT, S_DIV, S_DIV_DONE,
        S_ERRSET, S_REJSET, S_ESUM, S_FIN
    } state_t;

    typedef enum logic [1:0] { DIV_LAT, DIV_ERR, DIV_REJ } div_op_t;

    state_t  state_reg;
    div_op_t div_op_reg;

    // configuration
    logic [15:0]      window_reg;
    logic [23:0]      thresh_reg;
    logic [31:0]      auto_reg;

    // request capture
    logic [TIME_W-1:0] now_reg;
    logic [VAL_W-1:0] val_reg;
    logic [RATE_W-1:0] rate_reg;
    logic             sel_rej_reg;

    // ring bookkeeping
    logic [LAT_AW-1:0]  lat_head_reg;
    logic [LAT_CW-1:0]  lat_count_reg;
    logic [LSUM_W-1:0]  lat_sum_reg;
    logic [LSQ_W-1:0]   lat_sq_reg;
    logic [RATE_AW-1:0] err_head_reg, rej_head_reg;
    logic [RATE_CW-1:0] err_count_reg, rej_count_reg;
    logic [RSUM_W-1:0]  err_sum_reg, rej_sum_reg;

    logic [SCORE_W-1:0] score_reg;
    logic [1:0]         mode_reg;
    logic [TIME_W-1:0]  last_reset_reg;
    logic               tripped_reg;

    // arithmetic
    logic [VAL_W-1:0]   dv_reg;
    logic [2*VAL_W-1:0] prod_reg;
    logic [NQ_W-1:0]    nq_reg;
    logic [SS_W-1:0]    ss_reg;
    logic [D_W-1:0]     d_reg;
    logic [ROOT_W+1:0]  srem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [DIV_W-1:0]   q_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DVS_W-1:0]   drem_reg;
    logic [5:0]         iter_reg;
    logic [DIV_W-3:0]   lat_part_reg;
    logic [14:0]        err_part_reg;
    logic [13:0]        rej_part_reg;

    // memories
    logic               lat_we;
    logic [LAT_AW-1:0]  lat_waddr;
    logic [LENT_W-1:0]  lat_rdata;
    logic               rate_we;
    logic [RATE_MEM_AW-1:0] rate_addr;
    logic [RATE_W-1:0]  rate_rdata;

    logic               out_free;

    // rate ring head of the selected kind; rejections live in the upper half
    logic [RATE_AW-1:0] rhead;
    logic [RATE_CW-1:0] rcount;
    assign rhead  = sel_rej_reg ? rej_head_reg : err_head_reg;
    assign rcount = sel_rej_reg ? rej_count_reg : err_count_reg;
    assign rate_addr = sel_rej_reg
        ? RATE_MEM_AW'(rhead) + RATE_MEM_AW'(RATE_DEPTH)
        : RATE_MEM_AW'(rhead);

    assign lat_we    = (state_reg == S_LWR);
    assign lat_waddr = lat_head_reg + lat_count_reg[LAT_AW-1:0];
    assign rate_we   = (state_reg == S_RWR);

    aks_ram #(.WIDTH(LENT_W), .DEPTH(LAT_DEPTH)) u_lat_ram (
        .clk   (clk),
        .we    (lat_we),
        .waddr (lat_waddr),
        .wdata ({now_reg, val_reg}),
        .raddr (lat_head_reg),
        .rdata (lat_rdata)
    );

    aks_ram #(.WIDTH(RATE_W), .DEPTH(2 * RATE_DEPTH)) u_rate_ram (
        .clk   (clk),
        .we    (rate_we),
        .waddr (rate_addr),
        .wdata (rate_reg),
        .raddr (rate_addr),
        .rdata (rate_rdata)
    );

    // entry fields from the latency ring
    logic [TIME_W-1:0] ent_time;
    logic [VAL_W-1:0]  ent_val;
    logic [TIME_W-1:0] ent_age;
    assign ent_time = lat_rdata[LENT_W-1:VAL_W];
    assign ent_val  = lat_rdata[VAL_W-1:0];
    assign ent_age  = now_reg - ent_time;

    // one square root step: two radicand bits per cycle
    logic [ROOT_W+3:0] srem_sh;
    logic [ROOT_W+3:0] strial;
    logic [ROOT_W+1:0] srem_next;
    logic [ROOT_W-1:0] root_next;
    always_comb
    begin
        srem_sh = {srem_reg, d_reg[D_W-1:D_W-2]};
        strial  = (ROOT_W+4)'({root_reg, 2'b01});
        if (srem_sh >= strial)
        begin
            srem_next = (ROOT_W+2)'(srem_sh - strial);
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            srem_next = srem_sh[ROOT_W+1:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    // one restoring divider step
    logic [DVS_W:0]   drem_sh;
    logic [DVS_W-1:0] drem_next;
    logic             qbit;
    always_comb
    begin
        drem_sh = {drem_reg, q_reg[DIV_W-1]};
        if (drem_sh >= {1'b0, dvs_reg})
        begin
            drem_next = DVS_W'(drem_sh - {1'b0, dvs_reg});
            qbit      = 1'b1;
        end
        else
        begin
            drem_next = drem_sh[DVS_W-1:0];
            qbit      = 1'b0;
        end
    end

    logic [DIV_W-2:0]   total;
    logic [SCORE_W-1:0] score_next;
    always_comb
    begin
        total = (DIV_W-1)'(lat_part_reg) + (DIV_W-1)'(err_part_reg)
              + (DIV_W-1)'(rej_part_reg);
        score_next = (total > (DIV_W-1)'({SCORE_W{1'b1}}))
            ? {SCORE_W{1'b1}} : total[SCORE_W-1:0];
    end

    logic [RSUM_W+1:0] err3;
    assign err3 = {1'b0, err_sum_reg, 1'b0} + (RSUM_W+2)'(err_sum_reg);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !m_axis_tvalid || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            div_op_reg     <= DIV_LAT;
            window_reg     <= 16'd1000;
            thresh_reg     <= 24'd52429;
            auto_reg       <= 32'd60000;
            now_reg        <= '0;
            val_reg        <= '0;
            rate_reg       <= '0;
            sel_rej_reg    <= 1'b0;
            lat_head_reg   <= '0;
            lat_count_reg  <= '0;
            lat_sum_reg    <= '0;
            lat_sq_reg     <= '0;
            err_head_reg   <= '0;
            err_count_reg  <= '0;
            err_sum_reg    <= '0;
            rej_head_reg   <= '0;
            rej_count_reg  <= '0;
            rej_sum_reg    <= '0;
            score_reg      <= '0;
            mode_reg       <= MODE_CLOSED;
            last_reset_reg <= '0;
            tripped_reg    <= 1'b0;
            dv_reg         <= '0;
            prod_reg       <= '0;
            nq_reg         <= '0;
            ss_reg         <= '0;
            d_reg          <= '0;
            srem_reg       <= '0;
            root_reg       <= '0;
            q_reg          <= '0;
            dvs_reg        <= '0;
            drem_reg       <= '0;
            iter_reg       <= '0;
            lat_part_reg   <= '0;
            err_part_reg   <= '0;
            rej_part_reg   <= '0;
            m_axis_tvalid  <= 1'b0;
            m_axis_tdata   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW:    window_reg <= cfg_wdata[15:0];
                    REG_THRESHOLD: thresh_reg <= cfg_wdata[23:0];
                    REG_AUTORESET: auto_reg   <= cfg_wdata;
                    default: ;
                endcase
            end

            // in the final state a taken result is replaced below
            if (m_axis_tvalid && m_axis_tready && state_reg != S_FIN)
            begin
                m_axis_tvalid <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        now_reg     <= s_axis_tdata[31:0];
                        val_reg     <= s_axis_tdata[55:32];
                        rate_reg    <= (s_axis_tdata[55:48] != 8'd0)
                                       ? {RATE_W{1'b1}} : s_axis_tdata[47:32];
                        sel_rej_reg <= (s_axis_tuser == CMD_REJECT);
                        tripped_reg <= 1'b0;
                        unique case (s_axis_tuser)
                            CMD_LATENCY:
                                state_reg <= (lat_count_reg == LAT_CW'(LAT_DEPTH))
                                             ? S_LRD_FULL : S_LWR;
                            CMD_ERROR:
                                state_reg <= (err_count_reg >= RATE_CW'(RATE_DEPTH))
                                             ? S_RRD : S_RWR;
                            CMD_REJECT:
                                state_reg <= (rej_count_reg >= RATE_CW'(RATE_DEPTH))
                                             ? S_RRD : S_RWR;
                            CMD_TICK:
                            begin
                                if (mode_reg == MODE_OPEN &&
                                    (s_axis_tdata[31:0] - last_reset_reg) >= auto_reg)
                                begin
                                    mode_reg <= MODE_HALF;
                                end
                                state_reg <= S_FIN;
                            end
                            CMD_RESET:
                            begin
                                lat_head_reg   <= '0;
                                lat_count_reg  <= '0;
                                lat_sum_reg    <= '0;
                                lat_sq_reg     <= '0;
                                err_head_reg   <= '0;
                                err_count_reg  <= '0;
                                err_sum_reg    <= '0;
                                rej_head_reg   <= '0;
                                rej_count_reg  <= '0;
                                rej_sum_reg    <= '0;
                                score_reg      <= '0;
                                mode_reg       <= MODE_CLOSED;
                                last_reset_reg <= s_axis_tdata[31:0];
                                state_reg      <= S_FIN;
                            end
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end
                // full ring: retire the oldest sample first
                S_LRD_FULL: state_reg <= S_LSQ_FULL;
                S_LSQ_FULL:
                begin
                    dv_reg    <= ent_val;
                    prod_reg  <= ent_val * ent_val;
                    state_reg <= S_LSUB_FULL;
                end
                S_LSUB_FULL:
                begin
                    lat_sum_reg   <= lat_sum_reg - LSUM_W'(dv_reg);
                    lat_sq_reg    <= lat_sq_reg - LSQ_W'(prod_reg);
                    lat_head_reg  <= lat_head_reg + 1'b1;
                    lat_count_reg <= lat_count_reg - 1'b1;
                    state_reg     <= S_LWR;
                end
                S_LWR:
                begin
                    prod_reg  <= val_reg * val_reg;
                    state_reg <= S_LADD;
                end
                S_LADD:
                begin
                    lat_sum_reg   <= lat_sum_reg + LSUM_W'(val_reg);
                    lat_sq_reg    <= lat_sq_reg + LSQ_W'(prod_reg);
                    lat_count_reg <= lat_count_reg + 1'b1;
                    state_reg     <= S_PRD;
                end
                // window pruning walks from the oldest end
                S_PRD: state_reg <= S_PCHK;
                S_PCHK:
                begin
                    if (lat_count_reg != '0 && ent_age > TIME_W'(window_reg))
                    begin
                        dv_reg    <= ent_val;
                        prod_reg  <= ent_val * ent_val;
                        state_reg <= S_PSUB;
                    end
                    else
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_PSUB:
                begin
                    lat_sum_reg   <= lat_sum_reg - LSUM_W'(dv_reg);
                    lat_sq_reg    <= lat_sq_reg - LSQ_W'(prod_reg);
                    lat_head_reg  <= lat_head_reg + 1'b1;
                    lat_count_reg <= lat_count_reg - 1'b1;
                    state_reg     <= S_PRD;
                end
                // rate rings: read the overwritten entry, then write
                S_RRD: state_reg <= S_RSUB;
                S_RSUB:
                begin
                    if (sel_rej_reg)
                    begin
                        rej_sum_reg   <= rej_sum_reg - RSUM_W'(rate_rdata);
                        rej_count_reg <= rej_count_reg - 1'b1;
                    end
                    else
                    begin
                        err_sum_reg   <= err_sum_reg - RSUM_W'(rate_rdata);
                        err_count_reg <= err_count_reg - 1'b1;
                    end
                    state_reg <= S_RWR;
                end
                S_RWR:
                begin
                    if (sel_rej_reg)
                    begin
                        rej_sum_reg   <= rej_sum_reg + RSUM_W'(rate_reg);
                        rej_count_reg <= rcount + 1'b1;
                        rej_head_reg  <= (rhead == RATE_AW'(RATE_DEPTH - 1))
                                         ? '0 : rhead + 1'b1;
                    end
                    else
                    begin
                        err_sum_reg   <= err_sum_reg + RSUM_W'(rate_reg);
                        err_count_reg <= rcount + 1'b1;
                        err_head_reg  <= (rhead == RATE_AW'(RATE_DEPTH - 1))
                                         ? '0 : rhead + 1'b1;
                    end
                    state_reg <= S_EVAL;
                end
                // score engine
                S_EVAL: state_reg <= (lat_count_reg == '0) ? S_FIN : S_EMUL;
                S_EMUL:
                begin
                    nq_reg    <= lat_count_reg * lat_sq_reg;
                    ss_reg    <= lat_sum_reg * lat_sum_reg;
                    state_reg <= S_ESUB;
                end
                S_ESUB:
                begin
                    d_reg     <= (NQ_W'(ss_reg) <= nq_reg)
                                 ? D_W'(nq_reg - NQ_W'(ss_reg)) : '0;
                    srem_reg  <= '0;
                    root_reg  <= '0;
                    iter_reg  <= 6'(ROOT_W);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    srem_reg <= srem_next;
                    root_reg <= root_next;
                    d_reg    <= {d_reg[D_W-3:0], 2'b00};
                    if (iter_reg == 6'd1)
                    begin
                        div_op_reg <= DIV_LAT;
                        state_reg  <= S_DIV;
                        iter_reg   <= 6'(DIV_W - 2);
                        drem_reg   <= '0;
                        dvs_reg    <= DVS_W'(lat_sum_reg) + DVS_W'(lat_count_reg);
                        q_reg      <= {root_next, 17'd0};
                    end
                    else
                    begin
                        iter_reg <= iter_reg - 1'b1;
                    end
                end
                S_DIV:
                begin
                    drem_reg <= drem_next;
                    q_reg    <= {q_reg[DIV_W-2:0], qbit};
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == 6'd1)
                    begin
                        state_reg <= S_DIV_DONE;
                    end
                end
                S_DIV_DONE:
                begin
                    unique case (div_op_reg)
                        DIV_LAT:
                        begin
                            lat_part_reg <= q_reg[DIV_W-3:0];
                            state_reg    <= S_ERRSET;
                        end
                        DIV_ERR:
                        begin
                            err_part_reg <= (q_reg[24:0] > 25'(ERR_CAP))
                                            ? ERR_CAP : q_reg[14:0];
                            state_reg    <= S_REJSET;
                        end
                        default:
                        begin
                            rej_part_reg <= (q_reg[22:0] > 23'(REJ_CAP))
                                            ? REJ_CAP : q_reg[13:0];
                            state_reg    <= S_ESUM;
                        end
                    endcase
                end
                S_ERRSET:
                begin
                    if (err_count_reg != '0)
                    begin
                        div_op_reg <= DIV_ERR;
                        iter_reg   <= 6'd25;
                        drem_reg   <= '0;
                        dvs_reg    <= DVS_W'(err_count_reg);
                        q_reg      <= {err3[24:0], 23'd0};
                        state_reg  <= S_DIV;
                    end
                    else
                    begin
                        err_part_reg <= '0;
                        state_reg    <= S_REJSET;
                    end
                end
                S_REJSET:
                begin
                    if (rej_count_reg != '0)
                    begin
                        div_op_reg <= DIV_REJ;
                        iter_reg   <= 6'd23;
                        drem_reg   <= '0;
                        dvs_reg    <= DVS_W'(rej_count_reg);
                        q_reg      <= {rej_sum_reg, 25'd0};
                        state_reg  <= S_DIV;
                    end
                    else
                    begin
                        rej_part_reg <= '0;
                        state_reg    <= S_ESUM;
                    end
                end
                S_ESUM:
                begin
                    score_reg <= score_next;
                    if (score_next > thresh_reg && mode_reg == MODE_CLOSED)
                    begin
                        mode_reg    <= MODE_OPEN;
                        tripped_reg <= 1'b1;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata  <= {4'd0, tripped_reg, score_reg,
                                          (mode_reg == MODE_OPEN), mode_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_lat_count: assert property (@(posedge clk) disable iff (!rst_n)
        lat_count_reg <= LAT_CW'(LAT_DEPTH))
        else $error("latency ring count overflow");
    a_rate_count: assert property (@(posedge clk) disable iff (!rst_n)
        err_count_reg <= RATE_CW'(RATE_DEPTH) && rej_count_reg <= RATE_CW'(RATE_DEPTH))
        else $error("rate ring count overflow");
    a_half_stays: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HALF |=> mode_reg != MODE_OPEN)
        else $error("half-open switch reopened");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");
    a_trip_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[27] |-> m_axis_tdata[2])
        else $error("trip reported without blocking");
`endif
endmodule
`default_nettype wire
